### rtl/pidc_pkg.sv
`timescale 1ns / 1ps
// pidc_pkg.sv - widths, codes, item types and control bundles of the clamped PID controller.
// No dependencies; every module of the block imports it.
package pidc_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TS_WIDTH      = 24;
    localparam int INTEG_WIDTH   = 48;
    localparam int DERIV_WIDTH   = 64;

    // Multiplier digit: one 16-bit slice of the second operand per cycle.
    localparam int DIGIT_LOG = 4;
    localparam int DIGIT_W   = 1 << DIGIT_LOG;

    // Second operand is held one bit wider than the widest value it carries.
    localparam int OPY_WIDTH = DERIV_WIDTH + 1;
    // Exact sum of the three control products.
    localparam int ACC_WIDTH = DATA_WIDTH + DERIV_WIDTH + 2;

    localparam int DT_DIGITS    = (TS_WIDTH + 1 + DIGIT_W - 1) / DIGIT_W;
    localparam int ERR_DIGITS   = (DATA_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int INTEG_DIGITS = (INTEG_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int DERIV_DIGITS = (DERIV_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int DIG_IDX_W    = $clog2(DERIV_DIGITS);

    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KP      = 3'd0,
        REG_KI      = 3'd1,
        REG_KD      = 3'd2,
        REG_OUT_MAX = 3'd3,
        REG_OUT_MIN = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_E,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_I,
        ST_WAIT_D,
        ST_MUL_D,
        ST_CLAMP
    } pidc_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ERR_DT,
        OP_KP_ERR,
        OP_KI_INT,
        OP_KD_DER
    } mac_op_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] error_in;
        logic [TS_WIDTH-1:0]   time_step;
    } pidc_in_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] drive_out;
        logic                  clamped;
    } pidc_out_t;

    typedef struct packed {
        logic    in_ready;
        logic    div_start;
        logic    acc_clear;
        mac_op_t mac_op;
        logic    integ_upd;
        logic    out_load;
    } pidc_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic mac_last;
        logic div_busy;
        logic out_free;
    } pidc_stat_t;

    typedef struct packed {
        logic                 clear;
        logic                 load;
        logic [DIG_IDX_W-1:0] last_idx;
    } pidc_mac_ctl_t;

endpackage

### rtl/pidc_div.sv
`timescale 1ns / 1ps
// pidc_div.sv - radix-4 restoring divider for the derivative term, saturating, signed result.
// Depends on pidc_pkg.
module pidc_div #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [pidc_pkg::DATA_WIDTH:0]      diff,
    input  logic [pidc_pkg::TS_WIDTH-1:0]      divisor,
    output logic                               busy,
    output logic [pidc_pkg::DERIV_WIDTH-1:0]   quot
);
    import pidc_pkg::*;

    localparam int NUM_W  = DATA_WIDTH + 1 + FRAC_BITS;
    localparam int NUM_W2 = NUM_W + (NUM_W % 2);
    localparam int STEPS  = NUM_W2 / 2;
    localparam int CNT_W  = $clog2(STEPS + 1);
    localparam int QX_W   = (NUM_W2 > DERIV_WIDTH) ? NUM_W2 : DERIV_WIDTH;
    localparam int MAG_W  = DERIV_WIDTH - 1;

    logic                   busy_reg, busy_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [NUM_W2-1:0]      num_reg, num_next;
    logic [TS_WIDTH-1:0]    rem_reg, rem_next;
    logic [TS_WIDTH-1:0]    dvs_reg, dvs_next;
    logic                   neg_reg, neg_next;
    logic [DERIV_WIDTH-1:0] quot_reg, quot_next;

    logic [DATA_WIDTH:0]    mag;
    logic [NUM_W2-1:0]      num_step;
    logic [TS_WIDTH-1:0]    rem_step;
    logic [TS_WIDTH:0]      trial;
    logic [QX_W-1:0]        q_ext;
    logic                   sat;
    logic [DERIV_WIDTH-1:0] q_mag;

    assign mag = diff[DATA_WIDTH] ? (~diff + 1'b1) : diff;

    // Two quotient bits per cycle; the quotient shifts in behind the dividend.
    always_comb
    begin
        num_step = num_reg;
        rem_step = rem_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++)
        begin
            trial = {rem_step, num_step[NUM_W2-1]};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial    = trial - {1'b0, dvs_reg};
                num_step = {num_step[NUM_W2-2:0], 1'b1};
            end
            else
            begin
                num_step = {num_step[NUM_W2-2:0], 1'b0};
            end
            rem_step = trial[TS_WIDTH-1:0];
        end
    end

    // Saturate the magnitude at the largest positive 64-bit value.
    assign q_ext = QX_W'(num_reg);
    assign sat   = |q_ext[QX_W-1:MAG_W];
    assign q_mag = sat ? {1'b0, {MAG_W{1'b1}}} : q_ext[DERIV_WIDTH-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            num_next  = NUM_W2'({mag, {FRAC_BITS{1'b0}}});
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = diff[DATA_WIDTH];
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
                num_next = num_step;
                rem_next = rem_step;
            end
            else
            begin
                busy_next = 1'b0;
                // Zero time step disables the derivative.
                if (dvs_reg == '0)
                begin
                    quot_next = '0;
                end
                else if (neg_reg)
                begin
                    quot_next = ~q_mag + 1'b1;
                end
                else
                begin
                    quot_next = q_mag;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

### rtl/pidc_mac.sv
`timescale 1ns / 1ps
// pidc_mac.sv - shared multiply-accumulate unit: one 16-bit digit of the second operand a cycle.
// Depends on pidc_pkg.
module pidc_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pidc_pkg::pidc_mac_ctl_t           ctl,
    input  logic [pidc_pkg::DATA_WIDTH-1:0]   x_in,
    input  logic [pidc_pkg::OPY_WIDTH-1:0]    y_in,
    output logic                              last,
    output logic [pidc_pkg::ACC_WIDTH-1:0]    acc
);
    import pidc_pkg::*;

    localparam int PP_W = DATA_WIDTH + DIGIT_W + 1;
    localparam int SH_W = DIG_IDX_W + DIGIT_LOG;

    logic                         busy_reg, busy_next;
    logic [DIG_IDX_W-1:0]         k_reg, k_next;
    logic [DIG_IDX_W-1:0]         last_reg, last_next;
    logic signed [DATA_WIDTH-1:0] x_reg, x_next;
    logic signed [OPY_WIDTH-1:0]  y_reg, y_next;
    logic signed [ACC_WIDTH-1:0]  acc_reg, acc_next;

    logic                         is_last;
    logic signed [DIGIT_W:0]      digit;
    logic signed [PP_W-1:0]       pp;
    logic signed [ACC_WIDTH-1:0]  pp_ext;
    logic [SH_W-1:0]              shamt;

    // Lower digits are unsigned slices; the top digit carries the sign.
    assign is_last = (k_reg == last_reg);
    assign digit   = is_last ? y_reg[DIGIT_W:0] : {1'b0, y_reg[DIGIT_W-1:0]};
    assign pp      = x_reg * digit;
    assign pp_ext  = ACC_WIDTH'(pp);
    assign shamt   = {k_reg, {DIGIT_LOG{1'b0}}};

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        last_next = last_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + (pp_ext << shamt);
        end
        if (busy_reg)
        begin
            k_next = k_reg + 1'b1;
            y_next = y_reg >>> DIGIT_W;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (ctl.load)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            last_next = ctl.last_idx;
            x_next    = x_in;
            y_next    = y_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
    end

    assign last = busy_reg && is_last;
    assign acc  = acc_reg;

    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> (k_reg <= last_reg))
        else $error("digit index ran past the last digit");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> (!busy_reg || is_last))
        else $error("operands reloaded in the middle of a product");

    assert property (@(posedge clk) disable iff (!rst_n) ctl.clear |-> !busy_reg)
        else $error("accumulator cleared while a product is running");

endmodule

### rtl/pidc_seq.sv
`timescale 1ns / 1ps
// pidc_seq.sv - sequencer: orders the products, the integral update and the output clamp.
// Depends on pidc_pkg.
module pidc_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pidc_pkg::pidc_stat_t stat,
    output pidc_pkg::pidc_ctrl_t ctrl
);
    import pidc_pkg::*;

    pidc_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctrl        = '0;
        ctrl.mac_op = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    ctrl.div_start = 1'b1;
                    ctrl.acc_clear = 1'b1;
                    ctrl.mac_op    = OP_ERR_DT;
                    state_next     = ST_MUL_E;
                end
            end
            ST_MUL_E:
            begin
                if (stat.mac_last)
                begin
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                ctrl.integ_upd = 1'b1;
                ctrl.acc_clear = 1'b1;
                ctrl.mac_op    = OP_KP_ERR;
                state_next     = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                if (stat.mac_last)
                begin
                    ctrl.mac_op = OP_KI_INT;
                    state_next  = ST_MUL_I;
                end
            end
            ST_MUL_I:
            begin
                if (stat.mac_last)
                begin
                    if (!stat.div_busy)
                    begin
                        ctrl.mac_op = OP_KD_DER;
                        state_next  = ST_MUL_D;
                    end
                    else
                    begin
                        state_next = ST_WAIT_D;
                    end
                end
            end
            ST_WAIT_D:
            begin
                if (!stat.div_busy)
                begin
                    ctrl.mac_op = OP_KD_DER;
                    state_next  = ST_MUL_D;
                end
            end
            ST_MUL_D:
            begin
                if (stat.mac_last)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_D) |-> !stat.div_busy)
        else $error("derivative product started before the divider finished");

    assert property (@(posedge clk) disable iff (!rst_n)
        stat.mac_last |-> (state_reg == ST_MUL_E || state_reg == ST_MUL_P ||
                           state_reg == ST_MUL_I || state_reg == ST_MUL_D))
        else $error("product finished outside a multiply state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !ctrl.in_ready)
        else $error("input offered ready while an item is in progress");

endmodule

### rtl/pid_controller_clamped_top.sv
`timescale 1ns / 1ps
// pid_controller_clamped_top.sv - clamped fixed-point PID controller, top level.
// Depends on pidc_pkg, pidc_div, pidc_mac, pidc_seq.
//
//  Port group   Direction  Handshake            Carries
//  ----------   ---------  -------------------  ---------------------------------------
//  cfg_*        in         cfg_we, no wait      gain and limit registers by index
//  in_item      in         in_valid/in_ready    error sample and time step
//  out_item     out        out_valid/out_ready  clamped drive and clamp flag
//
// An item is accepted only in the idle state, and the next item is taken only once the result
// has been loaded into the output register. The time per item is set by the radix-4
// derivative divider, which runs alongside the first three products.
// The shared multiply-accumulate unit handles 16 bits of one operand per cycle.
// Reset clears the state and loads the registers with their reset values at once.
// A result waits in the output register; only the clamp step stalls behind a full one.
module pid_controller_clamped_top #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pidc_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [pidc_pkg::DATA_WIDTH-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  pidc_pkg::pidc_in_t              in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output pidc_pkg::pidc_out_t             out_item
);
    import pidc_pkg::*;

    localparam logic signed [ACC_WIDTH-1:0] INTEG_MAX =
        ACC_WIDTH'({1'b0, {(INTEG_WIDTH - 1){1'b1}}});
    localparam logic signed [ACC_WIDTH-1:0] INTEG_MIN =
        ACC_WIDTH'($signed({1'b1, {(INTEG_WIDTH - 1){1'b0}}}));

    // Configuration registers.
    logic [DATA_WIDTH-1:0] kp_reg, kp_next;
    logic [DATA_WIDTH-1:0] ki_reg, ki_next;
    logic [DATA_WIDTH-1:0] kd_reg, kd_next;
    logic [DATA_WIDTH-1:0] out_max_reg, out_max_next;
    logic [DATA_WIDTH-1:0] out_min_reg, out_min_next;

    // Controller state.
    logic [DATA_WIDTH-1:0]  last_error_reg, last_error_next;
    logic [INTEG_WIDTH-1:0] integral_reg, integral_next;

    // Output register.
    logic      out_valid_reg, out_valid_next;
    pidc_out_t out_item_reg, out_item_next;

    pidc_ctrl_t    ctrl;
    pidc_stat_t    stat;
    pidc_mac_ctl_t mac_ctl;

    logic [DATA_WIDTH-1:0]  mac_x;
    logic [OPY_WIDTH-1:0]   mac_y;
    logic [DIG_IDX_W-1:0]   mac_last_idx;
    logic                   mac_last;
    logic [ACC_WIDTH-1:0]   acc;

    logic [DATA_WIDTH:0]    err_diff;
    logic                   div_busy;
    logic [DERIV_WIDTH-1:0] deriv;

    logic signed [ACC_WIDTH-1:0] acc_shr;
    logic signed [ACC_WIDTH-1:0] integ_sum;
    logic signed [ACC_WIDTH-1:0] lim_lo;
    logic signed [ACC_WIDTH-1:0] lim_hi;
    logic                        below_min;
    logic                        above_max;
    logic [DATA_WIDTH-1:0]       drive;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    assign stat.in_valid = in_valid;
    assign stat.mac_last = mac_last;
    assign stat.div_busy = div_busy;
    assign stat.out_free = !out_valid_reg || out_ready;

    pidc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign in_ready = ctrl.in_ready;

    // ---------------------------------------------------------------------
    // Derivative divider: started on accept with the fresh error difference,
    // it runs while the first three products go through the shared unit.
    // ---------------------------------------------------------------------
    assign err_diff = {in_item.error_in[DATA_WIDTH-1], in_item.error_in}
                    - {last_error_reg[DATA_WIDTH-1], last_error_reg};

    pidc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.div_start),
        .diff    (err_diff),
        .divisor (in_item.time_step),
        .busy    (div_busy),
        .quot    (deriv)
    );

    // ---------------------------------------------------------------------
    // Shared multiply-accumulate unit. Products in order:
    //   error * time_step      (integral increment, own accumulation)
    //   kp * error, ki * integral, kd * derivative  (summed exactly)
    // Select the operands for whichever product the sequencer loads.
    // ---------------------------------------------------------------------
    always_comb
    begin
        case (ctrl.mac_op)
            OP_ERR_DT:
            begin
                mac_x        = in_item.error_in;
                mac_y        = OPY_WIDTH'(in_item.time_step);
                mac_last_idx = DIG_IDX_W'(DT_DIGITS - 1);
            end
            OP_KP_ERR:
            begin
                mac_x        = kp_reg;
                mac_y        = OPY_WIDTH'($signed(last_error_reg));
                mac_last_idx = DIG_IDX_W'(ERR_DIGITS - 1);
            end
            OP_KI_INT:
            begin
                mac_x        = ki_reg;
                mac_y        = OPY_WIDTH'($signed(integral_reg));
                mac_last_idx = DIG_IDX_W'(INTEG_DIGITS - 1);
            end
            OP_KD_DER:
            begin
                mac_x        = kd_reg;
                mac_y        = OPY_WIDTH'($signed(deriv));
                mac_last_idx = DIG_IDX_W'(DERIV_DIGITS - 1);
            end
            default:
            begin
                mac_x        = '0;
                mac_y        = '0;
                mac_last_idx = '0;
            end
        endcase
    end

    assign mac_ctl.clear    = ctrl.acc_clear;
    assign mac_ctl.load     = (ctrl.mac_op != OP_NONE);
    assign mac_ctl.last_idx = mac_last_idx;

    pidc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .x_in  (mac_x),
        .y_in  (mac_y),
        .last  (mac_last),
        .acc   (acc)
    );

    // Both the increment and the final sum drop FRAC_BITS, rounding toward minus infinity.
    assign acc_shr = $signed(acc) >>> FRAC_BITS;

    // ---------------------------------------------------------------------
    // Integral update: add the increment, saturate to the signed 48-bit range.
    // ---------------------------------------------------------------------
    assign integ_sum = ACC_WIDTH'($signed(integral_reg)) + acc_shr;

    // ---------------------------------------------------------------------
    // Output clamp: minimum first, then maximum. With the limits crossed a
    // low sum ends at the maximum, so test the maximum against the minimum then.
    // ---------------------------------------------------------------------
    assign lim_lo    = ACC_WIDTH'($signed(out_min_reg));
    assign lim_hi    = ACC_WIDTH'($signed(out_max_reg));
    assign below_min = (acc_shr < lim_lo);
    assign above_max = below_min ? ($signed(out_max_reg) < $signed(out_min_reg))
                                 : (lim_hi < acc_shr);

    always_comb
    begin
        if (above_max)
        begin
            drive = out_max_reg;
        end
        else if (below_min)
        begin
            drive = out_min_reg;
        end
        else
        begin
            drive = acc_shr[DATA_WIDTH-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Next-state logic for configuration, controller state and output.
    // ---------------------------------------------------------------------
    always_comb
    begin
        kp_next      = kp_reg;
        ki_next      = ki_reg;
        kd_next      = kd_reg;
        out_max_next = out_max_reg;
        out_min_next = out_min_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_KP:      kp_next      = cfg_data;
                REG_KI:      ki_next      = cfg_data;
                REG_KD:      kd_next      = cfg_data;
                REG_OUT_MAX: out_max_next = cfg_data;
                REG_OUT_MIN: out_min_next = cfg_data;
                default:     ;  // drop writes to unlisted indexes
            endcase
        end
    end

    always_comb
    begin
        last_error_next = last_error_reg;
        integral_next   = integral_reg;
        // Take the new error on accept; the divider has already latched the difference.
        if (ctrl.div_start)
        begin
            last_error_next = in_item.error_in;
        end
        if (ctrl.integ_upd)
        begin
            if (integ_sum > INTEG_MAX)
            begin
                integral_next = INTEG_MAX[INTEG_WIDTH-1:0];
            end
            else if (integ_sum < INTEG_MIN)
            begin
                integral_next = INTEG_MIN[INTEG_WIDTH-1:0];
            end
            else
            begin
                integral_next = integ_sum[INTEG_WIDTH-1:0];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (ctrl.out_load)
        begin
            out_valid_next          = 1'b1;
            out_item_next.drive_out = drive;
            out_item_next.clamped   = below_min || above_max;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg         <= '0;
            ki_reg         <= '0;
            kd_reg         <= '0;
            out_max_reg    <= {1'b0, {(DATA_WIDTH - 1){1'b1}}};
            out_min_reg    <= {1'b1, {(DATA_WIDTH - 1){1'b0}}};
            last_error_reg <= '0;
            integral_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            kp_reg         <= kp_next;
            ki_reg         <= ki_next;
            kd_reg         <= kd_next;
            out_max_reg    <= out_max_next;
            out_min_reg    <= out_min_next;
            last_error_reg <= last_error_next;
            integral_reg   <= integral_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold the result payload; it needs no reset.
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
